// File: hw/rtl/lcic_pkg.sv
// Shared types and constants for the Luhn check and issuer class block.
`timescale 1ns / 1ps
package lcic_pkg;

  // Field widths fixed by the word format.
  localparam int IN_W    = 63;
  localparam int COUNT_W = 5;
  localparam int LEAD_W  = 7;
  localparam int CLASS_W = 2;
  localparam int DIGIT_W = 4;

  // Decimal storage: 19 digits cover every 63-bit value.
  localparam int BCD_DIGITS = 19;
  localparam int BCD_W      = BCD_DIGITS * DIGIT_W;

  // Binary to decimal conversion: 64 padded bits, eight bits per cycle.
  localparam int STEP_BITS  = 8;
  localparam int CONV_STEPS = 8;
  localparam int PAD_W      = STEP_BITS * CONV_STEPS;

  // Default number of low digits examined.
  localparam int MAX_DIGITS_DEF = 19;

  // Issuer class codes.
  typedef logic [CLASS_W-1:0] issuer_class_t;
  localparam issuer_class_t CLASS_NONE  = 2'd0;
  localparam issuer_class_t CLASS_LEN15 = 2'd1;
  localparam issuer_class_t CLASS_LEN16 = 2'd2;
  localparam issuer_class_t CLASS_FOUR  = 2'd3;

  // Length and prefix rules.
  localparam logic [COUNT_W-1:0] LEN_13       = 5'd13;
  localparam logic [COUNT_W-1:0] LEN_15       = 5'd15;
  localparam logic [COUNT_W-1:0] LEN_16       = 5'd16;
  localparam logic [LEAD_W-1:0]  PREFIX_34    = 7'd34;
  localparam logic [LEAD_W-1:0]  PREFIX_37    = 7'd37;
  localparam logic [LEAD_W-1:0]  PREFIX_51    = 7'd51;
  localparam logic [LEAD_W-1:0]  PREFIX_55    = 7'd55;
  localparam logic [DIGIT_W-1:0] FIRST_FOUR   = 4'd4;
  localparam logic [LEAD_W-1:0]  LEAD_MAX_VAL = 7'd99;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LOAD,
    ST_SCAN,
    ST_OUT
  } lcic_state_t;

  // Control to an iterative unit: load a new operand, or run one step.
  typedef struct packed {
    logic load;
    logic step;
  } lcic_ctrl_t;

  // Summary produced by the digit scan.
  typedef struct packed {
    logic               luhn_ok;
    logic [COUNT_W-1:0] count;
    logic [LEAD_W-1:0]  lead;
    logic [DIGIT_W-1:0] first;
  } lcic_scan_t;

endpackage

// File: hw/rtl/lcic_bin2bcd.sv
// Iterative binary to decimal converter, shift-and-add-three, eight bits per cycle.
`timescale 1ns / 1ps
module lcic_bin2bcd (
  input  logic                          clk,
  input  lcic_pkg::lcic_ctrl_t          ctrl,
  input  logic [lcic_pkg::IN_W-1:0]     bin_in,
  output logic [lcic_pkg::BCD_W-1:0]    bcd_out
);
  import lcic_pkg::*;

  logic [PAD_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;

  // Load takes the padded operand and clears the digits; a step runs eight shift-and-correct steps.
  always_comb begin
    int k;
    int j;
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctrl.load) begin
      bin_nxt = {{(PAD_W - IN_W){1'b0}}, bin_in};
      bcd_nxt = '0;
    end else if (ctrl.step) begin
      for (k = 0; k < STEP_BITS; k++) begin
        for (j = 0; j < BCD_DIGITS; j++) begin
          if (bcd_nxt[j*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            bcd_nxt[j*DIGIT_W +: DIGIT_W] = bcd_nxt[j*DIGIT_W +: DIGIT_W] + 4'd3;
          end
        end
        {bcd_nxt, bin_nxt} = {bcd_nxt[BCD_W-2:0], bin_nxt, 1'b0};
      end
    end
  end

  // Operand and digit registers carry no reset.
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign bcd_out = bcd_r;

endmodule

// File: hw/rtl/lcic_digit_scan.sv
// Digit scan: one decimal digit a cycle into the Luhn sum, count and leading digits.
`timescale 1ns / 1ps
module lcic_digit_scan #(
  parameter int MAX_DIGITS = lcic_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  lcic_pkg::lcic_ctrl_t          ctrl,
  input  logic [lcic_pkg::BCD_W-1:0]    bcd_in,
  output lcic_pkg::lcic_scan_t          result
);
  import lcic_pkg::*;

  localparam logic [COUNT_W:0] LUHN_MOD = 6'd10;

  logic [BCD_W-1:0]   dig_r,   dig_nxt;
  logic [COUNT_W-1:0] pos_r,   pos_nxt;
  logic [COUNT_W-1:0] msnz_r,  msnz_nxt;
  logic               any_r,   any_nxt;
  logic               upper_r, upper_nxt;
  logic [DIGIT_W-1:0] sum_r,   sum_nxt;
  logic [DIGIT_W-1:0] prev_r,  prev_nxt;
  logic [DIGIT_W-1:0] first_r, first_nxt;
  logic [LEAD_W-1:0]  lead_r,  lead_nxt;

  logic [DIGIT_W-1:0] digit;
  logic [DIGIT_W-1:0] weight;
  logic [COUNT_W:0]   sum_wide;

  // Contribution of one digit; doubled digits fold their two decimal digits.
  function automatic logic [DIGIT_W-1:0] luhn_weight(input logic [DIGIT_W-1:0] d,
                                                     input logic dbl);
    logic [DIGIT_W-1:0] w;
    w = d;
    if (dbl) begin
      case (d)
        4'd0:    w = 4'd0;
        4'd1:    w = 4'd2;
        4'd2:    w = 4'd4;
        4'd3:    w = 4'd6;
        4'd4:    w = 4'd8;
        4'd5:    w = 4'd1;
        4'd6:    w = 4'd3;
        4'd7:    w = 4'd5;
        4'd8:    w = 4'd7;
        4'd9:    w = 4'd9;
        default: w = 4'd0;
      endcase
    end
    return w;
  endfunction

  assign digit    = dig_r[DIGIT_W-1:0];
  assign weight   = luhn_weight(digit, pos_r[0]);
  assign sum_wide = {2'b00, sum_r} + {2'b00, weight};

  // Load clears the accumulators; each step consumes the lowest digit.
  always_comb begin
    dig_nxt   = dig_r;
    pos_nxt   = pos_r;
    msnz_nxt  = msnz_r;
    any_nxt   = any_r;
    upper_nxt = upper_r;
    sum_nxt   = sum_r;
    prev_nxt  = prev_r;
    first_nxt = first_r;
    lead_nxt  = lead_r;
    if (ctrl.load) begin
      dig_nxt   = bcd_in;
      pos_nxt   = '0;
      msnz_nxt  = '0;
      any_nxt   = 1'b0;
      upper_nxt = |(bcd_in >> (DIGIT_W * MAX_DIGITS));
      sum_nxt   = '0;
      prev_nxt  = '0;
      first_nxt = '0;
      lead_nxt  = '0;
    end else if (ctrl.step) begin
      dig_nxt  = dig_r >> DIGIT_W;
      pos_nxt  = pos_r + COUNT_W'(1);
      prev_nxt = digit;
      if (sum_wide >= LUHN_MOD) begin
        sum_nxt = DIGIT_W'(sum_wide - LUHN_MOD);
      end else begin
        sum_nxt = sum_wide[DIGIT_W-1:0];
      end
      // A non-zero digit becomes the most significant one seen so far.
      if (digit != '0) begin
        msnz_nxt = pos_r;
        any_nxt  = 1'b1;
        if (pos_r == '0) begin
          lead_nxt  = {3'b000, digit};
          first_nxt = '0;
        end else begin
          lead_nxt  = {digit, 3'b000} + {2'b00, digit, 1'b0} + {3'b000, prev_r};
          first_nxt = digit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dig_r   <= dig_nxt;
    pos_r   <= pos_nxt;
    msnz_r  <= msnz_nxt;
    any_r   <= any_nxt;
    upper_r <= upper_nxt;
    sum_r   <= sum_nxt;
    prev_r  <= prev_nxt;
    first_r <= first_nxt;
    lead_r  <= lead_nxt;
  end

  // The count saturates when digits above the examined ones are non-zero.
  always_comb begin
    result.luhn_ok = (sum_r == '0);
    result.lead    = lead_r;
    result.first   = first_r;
    if (upper_r) begin
      result.count = COUNT_W'(MAX_DIGITS);
    end else if (any_r) begin
      result.count = msnz_r + COUNT_W'(1);
    end else begin
      result.count = '0;
    end
  end

endmodule

// File: hw/rtl/luhn_check_and_issuer_class.sv
// Top level: sequencer, issuer classification and output register.
`timescale 1ns / 1ps
// Checks one account number per word with the Luhn mod-10 test and classifies its issuer.
// The number is first converted to decimal by a shift-and-add-three unit that takes eight
// bits a cycle over a 64-bit padded operand; the digits are then loaded into the scanner and
// scanned one a cycle from the least significant upward. The scan result goes to the output
// register once that register is free or the word it holds is being taken.
// in_ready is high only while the block is idle; a finished result waits in the output
// register, so the next word may be taken while it is still held.
module luhn_check_and_issuer_class #(
  parameter int MAX_DIGITS = lcic_pkg::MAX_DIGITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lcic_pkg::IN_W-1:0]        in_card_number,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_luhn_ok,
  output logic [lcic_pkg::COUNT_W-1:0]     out_digit_count,
  output logic [lcic_pkg::LEAD_W-1:0]      out_leading_digits,
  output logic [lcic_pkg::CLASS_W-1:0]     out_issuer_class
);
  import lcic_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS);
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(CONV_STEPS - 1);
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(MAX_DIGITS - 1);

  lcic_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r,   cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               luhn_ok_r;
  logic [COUNT_W-1:0] count_r;
  logic [LEAD_W-1:0]  lead_r;
  issuer_class_t      class_r;

  lcic_ctrl_t         conv_ctrl;
  lcic_ctrl_t         scan_ctrl;
  logic               out_load;
  logic [BCD_W-1:0]   bcd;
  lcic_scan_t         scan_res;
  issuer_class_t      class_calc;

  lcic_bin2bcd u_bin2bcd (
    .clk     (clk),
    .ctrl    (conv_ctrl),
    .bin_in  (in_card_number),
    .bcd_out (bcd)
  );

  lcic_digit_scan #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_digit_scan (
    .clk    (clk),
    .ctrl   (scan_ctrl),
    .bcd_in (bcd),
    .result (scan_res)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (cnt_r == CONV_LAST) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_r == SCAN_LAST) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    conv_ctrl = '0;
    scan_ctrl = '0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        conv_ctrl.load = in_valid;
      end
      ST_CONV: begin
        conv_ctrl.step = 1'b1;
      end
      ST_LOAD: begin
        scan_ctrl.load = 1'b1;
      end
      ST_SCAN: begin
        scan_ctrl.step = 1'b1;
      end
      ST_OUT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Step counter shared by the conversion and scan phases.
  always_comb begin
    if (state_r == ST_CONV || state_r == ST_SCAN) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      cnt_nxt = '0;
    end
  end

  // Issuer class from length and prefix, tried in order, only on a Luhn pass.
  always_comb begin
    class_calc = CLASS_NONE;
    if (scan_res.luhn_ok) begin
      if (scan_res.count == LEN_15 &&
          (scan_res.lead == PREFIX_34 || scan_res.lead == PREFIX_37)) begin
        class_calc = CLASS_LEN15;
      end else if (scan_res.count == LEN_16 &&
                   scan_res.lead inside {[PREFIX_51:PREFIX_55]}) begin
        class_calc = CLASS_LEN16;
      end else if (scan_res.count inside {LEN_13, LEN_16} &&
                   scan_res.first == FIRST_FOUR) begin
        class_calc = CLASS_FOUR;
      end
    end
  end

  // Output word is held until the consumer takes it.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      luhn_ok_r <= scan_res.luhn_ok;
      count_r   <= scan_res.count;
      lead_r    <= scan_res.lead;
      class_r   <= class_calc;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_luhn_ok        = luhn_ok_r;
  assign out_digit_count    = count_r;
  assign out_leading_digits = lead_r;
  assign out_issuer_class   = class_r;

  // A word taken in leaves the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block ready again straight after accepting a word");

  // Any issuer class other than none implies a Luhn pass.
  a_class_needs_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_issuer_class != CLASS_NONE) |-> out_luhn_ok)
    else $error("issuer class given without a Luhn pass");

  // A classified number has one of the lengths the rules allow.
  a_class_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_issuer_class != CLASS_NONE) |->
      (out_digit_count == LEN_13 || out_digit_count == LEN_15 ||
       out_digit_count == LEN_16))
    else $error("issuer class given for an unsupported length");

  // Count and leading digits stay within their decimal ranges.
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_count <= COUNT_W'(MAX_DIGITS) &&
                   out_leading_digits <= LEAD_MAX_VAL))
    else $error("digit count or leading digits out of range");

endmodule
